### src/mrps_pkg.sv
// ----------------------------------------------------------------------------
// mrps_pkg : shared types and constants of the mean reverting step unit
// request and result formats, method codes, fixed-point constants and the
// latencies of the pipelined arithmetic units
// ----------------------------------------------------------------------------
package mrps_pkg;

    // request of one transition
    typedef struct packed {
        logic signed [31:0] current_value;
        logic        [23:0] time_step;
        logic signed [15:0] noise_main;
        logic signed [15:0] noise_aux;
    } req_t;

    // result of one transition
    typedef struct packed {
        logic signed [31:0] next_value;
        logic               saturated;
    } rsp_t;

    // update method codes, code 3 behaves as exact
    typedef enum logic [1:0] {
        METHOD_EXACT   = 2'd0,
        METHOD_MIXTURE = 2'd1,
        METHOD_EULER   = 2'd2
    } method_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LONG_RUN_MEAN       = 2'd0,
        REG_STATIONARY_VARIANCE = 2'd1,
        REG_REVERSION_RATE      = 2'd2,
        REG_UPDATE_METHOD       = 2'd3
    } reg_index_t;

    localparam int unsigned VALUE_FRAC_BITS_DEFAULT = 16;

    // fixed-point constants
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [29:0] X_CAP_Q24 = 30'h2000_0000;
    localparam logic [38:0] EM1_CAP   = 39'h7F_FFFF_FFFF;

    // arithmetic unit sizes and latencies
    localparam int unsigned EXP_TERMS = 12;
    localparam int unsigned LAT_EXP   = 3 * EXP_TERMS + 3;
    localparam int unsigned DIV_BITS  = 48;
    localparam int unsigned LAT_DIV   = DIV_BITS + 2;
    localparam int unsigned SQRT_BITS = 32;
    localparam int unsigned LAT_SQRT  = SQRT_BITS;

endpackage

### src/mrps_exp.sv
// ----------------------------------------------------------------------------
// mrps_exp : pipelined exp(-x)
// x in Q.24 (at most 32.0), result Q.32; base-2 range reduction followed by a
// twelve-term nested series, three register stages per term
// ----------------------------------------------------------------------------
module mrps_exp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [29:0] x_in,
    output logic        out_valid,
    output logic [32:0] e_out
);

    typedef struct packed {
        logic [31:0] r;
        logic [4:0]  k;
        logic        big;
    } carry_t;

    localparam int unsigned TERMS = mrps_pkg::EXP_TERMS;

    logic [36:0] y_reg;
    logic        v0_reg;
    carry_t      c0_reg;
    logic        v1_reg;

    logic [60:0] y_prod;
    logic [61:0] r_prod;
    logic [6:0]  k_full;

    logic [31:0] p_reg   [TERMS];
    carry_t      ca_reg  [TERMS];
    logic        va_reg  [TERMS];
    logic [31:0] q0_reg  [TERMS];
    logic [31:0] pb_reg  [TERMS];
    carry_t      cb_reg  [TERMS];
    logic        vb_reg  [TERMS];
    logic [32:0] acc_reg [TERMS];
    carry_t      cc_reg  [TERMS];
    logic        vc_reg  [TERMS];

    logic [32:0] e_reg;
    logic        ve_reg;

    // log2(e) scaling, then split into integer and fraction
    assign y_prod = 61'(x_in) * 61'(mrps_pkg::LOG2E_Q30);
    assign k_full = y_reg[36:30];
    assign r_prod = 62'(y_reg[29:0]) * 62'(mrps_pkg::LN2_Q32);

    always_ff @(posedge clk)
    begin
        y_reg     <= y_prod[60:24];
        c0_reg.r  <= r_prod[61:30];
        c0_reg.k  <= k_full[4:0];
        c0_reg.big <= |k_full[6:5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    for (genvar i = 0; i < TERMS; i++)
    begin : g_term
        localparam int unsigned N = TERMS - i;
        localparam logic [36:0] RECIP = 37'((64'd1 << 36) / N);

        logic [32:0] acc_in;
        carry_t      c_in;
        logic        v_in;
        logic [64:0] prod_a;
        logic [68:0] prod_b;
        logic [35:0] qn;
        logic [35:0] rem;
        logic [31:0] q;

        if (i == 0)
        begin : g_first
            assign acc_in = mrps_pkg::ONE_Q32;
            assign c_in   = c0_reg;
            assign v_in   = v1_reg;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[i-1];
            assign c_in   = cc_reg[i-1];
            assign v_in   = vc_reg[i-1];
        end

        // product, reciprocal estimate, then one correction step
        assign prod_a = 65'(c_in.r) * 65'(acc_in);
        assign prod_b = 69'(p_reg[i]) * 69'(RECIP);
        assign qn     = 36'(q0_reg[i]) * 36'(N);
        assign rem    = 36'(pb_reg[i]) - qn;
        assign q      = q0_reg[i] + 32'(rem >= 36'(N));

        always_ff @(posedge clk)
        begin
            p_reg[i]   <= prod_a[63:32];
            ca_reg[i]  <= c_in;
            q0_reg[i]  <= prod_b[67:36];
            pb_reg[i]  <= p_reg[i];
            cb_reg[i]  <= ca_reg[i];
            acc_reg[i] <= mrps_pkg::ONE_Q32 - {1'b0, q};
            cc_reg[i]  <= cb_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[i] <= 1'b0;
                vb_reg[i] <= 1'b0;
                vc_reg[i] <= 1'b0;
            end
            else
            begin
                va_reg[i] <= v_in;
                vb_reg[i] <= va_reg[i];
                vc_reg[i] <= vb_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= cc_reg[TERMS-1].big ? '0 : (acc_reg[TERMS-1] >> cc_reg[TERMS-1].k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else
            ve_reg <= vc_reg[TERMS-1];
    end

    assign e_out     = e_reg;
    assign out_valid = ve_reg;

endmodule

### src/mrps_div.sv
// ----------------------------------------------------------------------------
// mrps_div : pipelined growth factor e^x - 1
// computes floor((1 - E) / E) in Q.16 by restoring division, one quotient
// bit per stage, saturated to 2^39 - 1 (also for E equal to zero)
// ----------------------------------------------------------------------------
module mrps_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [32:0] e_in,
    output logic        out_valid,
    output logic [38:0] q_out
);

    localparam int unsigned BITS = mrps_pkg::DIV_BITS;

    logic [32:0]     om;
    logic [32:0]     d0_reg;
    logic [BITS-1:0] n0_reg;
    logic            z0_reg;
    logic            v0_reg;

    logic [32:0]     rem_reg [BITS];
    logic [BITS-1:0] nq_reg  [BITS];
    logic [32:0]     d_reg   [BITS];
    logic            z_reg   [BITS];
    logic            v_reg   [BITS];

    logic [38:0]     q_reg;
    logic            vq_reg;

    assign om = mrps_pkg::ONE_Q32 - e_in;

    always_ff @(posedge clk)
    begin
        d0_reg <= e_in;
        n0_reg <= {om[31:0], 16'h0000};
        z0_reg <= (e_in == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    for (genvar j = 0; j < BITS; j++)
    begin : g_bit
        logic [32:0]     rem_in;
        logic [BITS-1:0] nq_in;
        logic [32:0]     d_in;
        logic            z_in;
        logic            v_in;
        logic [33:0]     t;
        logic [33:0]     t_sub;
        logic            ge;

        if (j == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = n0_reg;
            assign d_in   = d0_reg;
            assign z_in   = z0_reg;
            assign v_in   = v0_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign nq_in  = nq_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign z_in   = z_reg[j-1];
            assign v_in   = v_reg[j-1];
        end

        assign t     = {rem_in, nq_in[BITS-1]};
        assign ge    = (t >= {1'b0, d_in});
        assign t_sub = t - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? t_sub[32:0] : t[32:0];
            nq_reg[j]  <= {nq_in[BITS-2:0], ge};
            d_reg[j]   <= d_in;
            z_reg[j]   <= z_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (z_reg[BITS-1] || (nq_reg[BITS-1] > BITS'(mrps_pkg::EM1_CAP)))
            q_reg <= mrps_pkg::EM1_CAP;
        else
            q_reg <= nq_reg[BITS-1][38:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= 1'b0;
        else
            vq_reg <= v_reg[BITS-1];
    end

    assign q_out     = q_reg;
    assign out_valid = vq_reg;

endmodule

### src/mrps_sqrt.sv
// ----------------------------------------------------------------------------
// mrps_sqrt : pipelined integer square root
// floor(sqrt(v)) of a 64-bit value, one root bit per stage
// ----------------------------------------------------------------------------
module mrps_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] v_in,
    output logic        out_valid,
    output logic [31:0] root_out
);

    localparam int unsigned BITS = mrps_pkg::SQRT_BITS;

    logic [33:0] rem_reg  [BITS];
    logic [31:0] root_reg [BITS];
    logic [63:0] vs_reg   [BITS];
    logic        v_reg    [BITS];

    for (genvar i = 0; i < BITS; i++)
    begin : g_bit
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] vs_in;
        logic        vld_in;
        logic [35:0] t;
        logic [35:0] trial;
        logic [35:0] t_sub;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign vs_in   = v_in;
            assign vld_in  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign vs_in   = vs_reg[i-1];
            assign vld_in  = v_reg[i-1];
        end

        // bring down two radicand bits, try 4*root + 1
        assign t     = {rem_in, vs_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (t >= trial);
        assign t_sub = t - trial;

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? t_sub[33:0] : t[33:0];
            root_reg[i] <= {root_in[30:0], ge};
            vs_reg[i]   <= {vs_in[61:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= vld_in;
        end
    end

    assign root_out  = root_reg[BITS-1];
    assign out_valid = v_reg[BITS-1];

endmodule

### src/mean_reverting_process_step_unit.sv
// ----------------------------------------------------------------------------
// mean_reverting_process_step_unit : one Ornstein-Uhlenbeck transition per request
// exact, mixture or Euler update of a fixed-point mean reverting process
// ----------------------------------------------------------------------------
// usage
//   request channel: a request is taken at a rising edge with start high and
//   busy low; it carries the current value, the time step and two normal
//   samples. busy only stands high while in reset and the cycle after it.
//   result channel: result_valid marks the result for exactly one cycle; the
//   receiver cannot hold it off, and the block never needs it to.
//   config port: cfg_write with cfg_index and cfg_data writes a register at
//   once; write only while no request is in flight.
// timing
//   one request can be taken every cycle, so throughput is one per cycle.
//   each request passes through exp(-x), the growth divider and the square
//   root; the divider and the square root each produce one digit per stage,
//   while exp(-x) works through its series one term at a time.
// reset
//   all valid bits clear at once; registers return to mean 0, variance 1.0,
//   rate 1.0 and the exact method. there is no clearing pass.
// ----------------------------------------------------------------------------
module mean_reverting_process_step_unit #(
    parameter int unsigned VALUE_FRAC_BITS = mrps_pkg::VALUE_FRAC_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mrps_pkg::req_t  request,
    output logic            result_valid,
    output mrps_pkg::rsp_t  result,
    input  logic            cfg_write,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    // noise product is Q.28, brought down to value format
    localparam int unsigned NOISE_SHIFT = 28 - VALUE_FRAC_BITS;

    // delay line lengths, from where each value is made to where it is used
    localparam int unsigned X_D    = mrps_pkg::LAT_EXP;
    localparam int unsigned EUL_D  = mrps_pkg::LAT_EXP - 1;
    localparam int unsigned BASE_D = mrps_pkg::LAT_DIV + mrps_pkg::LAT_SQRT + 1;
    localparam int unsigned E2_D   = mrps_pkg::LAT_DIV;
    localparam int unsigned EVAR_D = mrps_pkg::LAT_EXP + mrps_pkg::LAT_DIV - 2;
    localparam int unsigned E_D    = mrps_pkg::LAT_DIV + mrps_pkg::LAT_SQRT + 1;
    localparam int unsigned Z_D    = mrps_pkg::LAT_EXP + mrps_pkg::LAT_DIV
                                     + mrps_pkg::LAT_SQRT + 1;
    localparam int unsigned Z1_D   = Z_D + 1;

    localparam logic signed [55:0] SAT_HI = 56'sh00_0000_7FFF_FFFF;
    localparam logic signed [55:0] SAT_LO = 56'shFF_FFFF_8000_0000;

    // configuration registers
    logic signed [31:0] mu_reg;
    logic        [23:0] tau_reg;
    logic        [23:0] alpha_reg;
    logic        [1:0]  method_reg;
    logic               busy_reg;
    logic               is_mixture;
    logic               is_euler;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg     <= '0;
            tau_reg    <= 24'h01_0000;
            alpha_reg  <= 24'h01_0000;
            method_reg <= mrps_pkg::METHOD_EXACT;
            busy_reg   <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (mrps_pkg::reg_index_t'(cfg_index))
                    mrps_pkg::REG_LONG_RUN_MEAN:       mu_reg     <= cfg_data;
                    mrps_pkg::REG_STATIONARY_VARIANCE: tau_reg    <= cfg_data[23:0];
                    mrps_pkg::REG_REVERSION_RATE:      alpha_reg  <= cfg_data[23:0];
                    mrps_pkg::REG_UPDATE_METHOD:       method_reg <= cfg_data[1:0];
                    default:                           mu_reg     <= mu_reg;
                endcase
            end
        end
    end

    assign busy       = busy_reg;
    assign is_mixture = (method_reg == mrps_pkg::METHOD_MIXTURE);
    assign is_euler   = (method_reg == mrps_pkg::METHOD_EULER);

    // ------------------------------------------------------------------
    // stage 1: alpha * dt
    // ------------------------------------------------------------------
    logic               v_s1_reg;
    logic        [47:0] x48_s1_reg;
    logic signed [31:0] x_s1_reg;
    logic signed [15:0] z_s1_reg;
    logic signed [15:0] z1_s1_reg;

    always_ff @(posedge clk)
    begin
        x48_s1_reg <= 48'(alpha_reg) * 48'(request.time_step);
        x_s1_reg   <= request.current_value;
        z_s1_reg   <= request.noise_main;
        z1_s1_reg  <= request.noise_aux;
    end

    // ------------------------------------------------------------------
    // stage 2: clamp x and 2x for the exponentials, euler deviation
    // ------------------------------------------------------------------
    logic               v_s2_reg;
    logic        [29:0] x24_s2_reg;
    logic        [29:0] x2_s2_reg;
    logic        [47:0] x48_s2_reg;
    logic signed [31:0] x_s2_reg;
    logic signed [32:0] d_s2_reg;
    logic signed [15:0] z_s2_reg;
    logic signed [15:0] z1_s2_reg;

    logic [39:0] x24_full;
    logic [29:0] x24_clamp;
    logic [30:0] x2_full;
    logic [29:0] x2_next;

    assign x24_full  = x48_s1_reg[47:8];
    assign x24_clamp = (x24_full > 40'(mrps_pkg::X_CAP_Q24)) ? mrps_pkg::X_CAP_Q24
                                                              : x24_full[29:0];
    assign x2_full   = {x24_clamp, 1'b0};
    assign x2_next   = (x2_full > 31'(mrps_pkg::X_CAP_Q24)) ? mrps_pkg::X_CAP_Q24
                                                             : x2_full[29:0];

    always_ff @(posedge clk)
    begin
        x24_s2_reg <= x24_clamp;
        x2_s2_reg  <= x2_next;
        x48_s2_reg <= x48_s1_reg;
        x_s2_reg   <= x_s1_reg;
        d_s2_reg   <= {mu_reg[31], mu_reg} - {x_s1_reg[31], x_s1_reg};
        z_s2_reg   <= z_s1_reg;
        z1_s2_reg  <= z1_s1_reg;
    end

    // ------------------------------------------------------------------
    // stages 3 and 4: euler drift and variance
    // ------------------------------------------------------------------
    logic               neg_s3_reg;
    logic        [48:0] mag_hi_s3_reg;
    logic        [32:0] mag_lo_s3_reg;
    logic        [39:0] tvh_s3_reg;
    logic        [39:0] tvl_s3_reg;
    logic signed [31:0] x_s3_reg;

    logic [32:0] ad;
    logic [64:0] mag_lo_prod;
    logic [55:0] tvl_prod;

    assign ad          = d_s2_reg[32] ? 33'(-d_s2_reg) : 33'(d_s2_reg);
    assign mag_lo_prod = 65'(ad) * 65'(x48_s2_reg[31:0]);
    assign tvl_prod    = 56'(tau_reg) * 56'(x48_s2_reg[31:0]);

    always_ff @(posedge clk)
    begin
        neg_s3_reg    <= d_s2_reg[32];
        mag_hi_s3_reg <= 49'(ad) * 49'(x48_s2_reg[47:32]);
        mag_lo_s3_reg <= mag_lo_prod[64:32];
        tvh_s3_reg    <= 40'(tau_reg) * 40'(x48_s2_reg[47:32]);
        tvl_s3_reg    <= tvl_prod[55:16];
        x_s3_reg      <= x_s2_reg;
    end

    logic signed [51:0] eul_base_s4_reg;
    logic        [57:0] eul_var_s4_reg;

    logic        [49:0] mag;
    logic signed [51:0] x_ext;
    logic        [56:0] var_half;

    assign mag      = 50'(mag_hi_s3_reg) + 50'(mag_lo_s3_reg);
    assign x_ext    = 52'(x_s3_reg);
    assign var_half = 57'({tvh_s3_reg, 16'h0000}) + 57'(tvl_s3_reg);

    always_ff @(posedge clk)
    begin
        eul_base_s4_reg <= neg_s3_reg ? (x_ext - $signed({2'b00, mag}))
                                      : (x_ext + $signed({2'b00, mag}));
        eul_var_s4_reg  <= {var_half, 1'b0};
    end

    // ------------------------------------------------------------------
    // exp(-x) and exp(-2x)
    // ------------------------------------------------------------------
    logic        ve_s41;
    logic        ve2_s41;
    logic [32:0] e_s41;
    logic [32:0] e2_s41;

    mrps_exp u_exp_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_s2_reg),
        .x_in      (x24_s2_reg),
        .out_valid (ve_s41),
        .e_out     (e_s41)
    );

    mrps_exp u_exp_x2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_s2_reg),
        .x_in      (x2_s2_reg),
        .out_valid (ve2_s41),
        .e_out     (e2_s41)
    );

    // ------------------------------------------------------------------
    // delay lines for payload that waits on the long units
    // ------------------------------------------------------------------
    logic signed [31:0] x_dly_reg    [X_D];
    logic signed [51:0] eul_dly_reg  [EUL_D];
    logic        [57:0] evar_dly_reg [EVAR_D];
    logic        [32:0] e2_dly_reg   [E2_D];
    logic        [32:0] e_dly_reg    [E_D];
    logic signed [15:0] z_dly_reg    [Z_D];
    logic signed [15:0] z1_dly_reg   [Z1_D];
    logic signed [51:0] base_dly_reg [BASE_D];
    logic signed [51:0] base_s43_reg;

    always_ff @(posedge clk)
    begin
        x_dly_reg[0]    <= x_s2_reg;
        eul_dly_reg[0]  <= eul_base_s4_reg;
        evar_dly_reg[0] <= eul_var_s4_reg;
        e2_dly_reg[0]   <= e2_s41;
        e_dly_reg[0]    <= e_s41;
        z_dly_reg[0]    <= z_s2_reg;
        z1_dly_reg[0]   <= z1_s2_reg;
        base_dly_reg[0] <= base_s43_reg;
        for (int i = 1; i < X_D; i++)
            x_dly_reg[i] <= x_dly_reg[i-1];
        for (int i = 1; i < EUL_D; i++)
            eul_dly_reg[i] <= eul_dly_reg[i-1];
        for (int i = 1; i < EVAR_D; i++)
            evar_dly_reg[i] <= evar_dly_reg[i-1];
        for (int i = 1; i < E2_D; i++)
            e2_dly_reg[i] <= e2_dly_reg[i-1];
        for (int i = 1; i < E_D; i++)
            e_dly_reg[i] <= e_dly_reg[i-1];
        for (int i = 1; i < Z_D; i++)
            z_dly_reg[i] <= z_dly_reg[i-1];
        for (int i = 1; i < Z1_D; i++)
            z1_dly_reg[i] <= z1_dly_reg[i-1];
        for (int i = 1; i < BASE_D; i++)
            base_dly_reg[i] <= base_dly_reg[i-1];
    end

    // ------------------------------------------------------------------
    // stages 42 and 43: blended mean, or the euler base
    // ------------------------------------------------------------------
    logic signed [65:0] bx_s42_reg;
    logic signed [65:0] bm_s42_reg;

    logic [32:0]        om_s41;
    logic signed [66:0] blend_sum;
    logic signed [31:0] blend;

    assign om_s41 = mrps_pkg::ONE_Q32 - e_s41;

    always_ff @(posedge clk)
    begin
        bx_s42_reg <= 66'(x_dly_reg[X_D-1]) * 66'($signed({1'b0, e_s41}));
        bm_s42_reg <= 66'(mu_reg) * 66'($signed({1'b0, om_s41}));
    end

    // floor shift by 32; the blended mean always fits the value range
    assign blend_sum = 67'(bx_s42_reg) + 67'(bm_s42_reg);
    assign blend     = blend_sum[63:32];

    always_ff @(posedge clk)
    begin
        base_s43_reg <= is_euler ? eul_dly_reg[EUL_D-1] : 52'(blend);
    end

    // ------------------------------------------------------------------
    // growth factor for the mixture form
    // ------------------------------------------------------------------
    logic        vq_s91;
    logic [38:0] q_s91;

    mrps_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ve_s41),
        .e_in      (e_s41),
        .out_valid (vq_s91),
        .q_out     (q_s91)
    );

    // ------------------------------------------------------------------
    // stage 92: variance per method
    // ------------------------------------------------------------------
    logic        v_s92_reg;
    logic [63:0] var_s92_reg;
    logic [63:0] var_next;
    logic [32:0] om2;
    logic [56:0] exact_prod;

    assign om2        = mrps_pkg::ONE_Q32 - e2_dly_reg[E2_D-1];
    assign exact_prod = 57'(tau_reg) * 57'(om2);

    always_comb
    begin
        priority if (is_euler)
            var_next = 64'(evar_dly_reg[EVAR_D-1]);
        else if (is_mixture)
            var_next = 64'(tau_reg) * 64'(q_s91);
        else
            var_next = 64'(exact_prod[56:16]);
    end

    always_ff @(posedge clk)
    begin
        var_s92_reg <= var_next;
    end

    // ------------------------------------------------------------------
    // standard deviation
    // ------------------------------------------------------------------
    logic        vs_s124;
    logic [31:0] sd_s124;

    mrps_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_s92_reg),
        .v_in      (var_s92_reg),
        .out_valid (vs_s124),
        .root_out  (sd_s124)
    );

    // ------------------------------------------------------------------
    // stages 125 to 128: noise terms, sum, saturation
    // ------------------------------------------------------------------
    logic               v_s125_reg;
    logic               v_s126_reg;
    logic               v_s127_reg;
    logic               v_s128_reg;
    logic signed [48:0] nz_s125_reg;
    logic        [31:0] se_s125_reg;
    logic signed [48:0] nt_s126_reg;
    logic signed [48:0] nz1_s126_reg;
    logic signed [55:0] sum_s127_reg;
    mrps_pkg::rsp_t     result_reg;

    logic [64:0]        se_prod;
    logic signed [55:0] aux_term;

    assign se_prod  = 65'(sd_s124) * 65'(e_dly_reg[E_D-1]);
    assign aux_term = is_mixture ? 56'(nz1_s126_reg >>> NOISE_SHIFT) : 56'sd0;

    always_ff @(posedge clk)
    begin
        nz_s125_reg  <= 49'($signed({1'b0, sd_s124})) * 49'(z_dly_reg[Z_D-1]);
        se_s125_reg  <= se_prod[63:32];
        nt_s126_reg  <= nz_s125_reg >>> NOISE_SHIFT;
        nz1_s126_reg <= 49'($signed({1'b0, se_s125_reg})) * 49'(z1_dly_reg[Z1_D-1]);
        sum_s127_reg <= 56'(base_dly_reg[BASE_D-1]) + 56'(nt_s126_reg) + aux_term;
        if (sum_s127_reg > SAT_HI)
        begin
            result_reg.next_value <= SAT_HI[31:0];
            result_reg.saturated  <= 1'b1;
        end
        else if (sum_s127_reg < SAT_LO)
        begin
            result_reg.next_value <= SAT_LO[31:0];
            result_reg.saturated  <= 1'b1;
        end
        else
        begin
            result_reg.next_value <= sum_s127_reg[31:0];
            result_reg.saturated  <= 1'b0;
        end
    end

    // valid bits of the stages held in this module
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg   <= 1'b0;
            v_s2_reg   <= 1'b0;
            v_s92_reg  <= 1'b0;
            v_s125_reg <= 1'b0;
            v_s126_reg <= 1'b0;
            v_s127_reg <= 1'b0;
            v_s128_reg <= 1'b0;
        end
        else
        begin
            v_s1_reg   <= start && !busy_reg;
            v_s2_reg   <= v_s1_reg;
            v_s92_reg  <= vq_s91;
            v_s125_reg <= vs_s124;
            v_s126_reg <= v_s125_reg;
            v_s127_reg <= v_s126_reg;
            v_s128_reg <= v_s127_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = v_s128_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> v_s1_reg)
        else $error("accepted request did not enter the pipeline");

    a_exp_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ve_s41 == ve2_s41)
        else $error("exponential units out of step");

    a_var_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_s92_reg |-> !var_s92_reg[63])
        else $error("variance exceeds its range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.next_value == SAT_HI[31:0] || result.next_value == SAT_LO[31:0]))
        else $error("saturated result not at a range limit");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb : testbench of the mean reverting step unit
// drives requests through all three update methods under several register
// settings, predicts every transition in fixed point and checks each result
// against the oldest outstanding typed result or prediction
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC       = 16;
    localparam int          LATENCY    = 128;
    localparam longint      CYCLE_CAP  = 400000;
    localparam logic [63:0] ONE        = 64'h1_0000_0000;
    localparam logic [63:0] LOG2E      = 64'd1549082005;
    localparam logic [63:0] LN2        = 64'd2977044472;
    localparam logic [63:0] X_CAP      = 64'h2000_0000;
    localparam logic [63:0] GROWTH_CAP = 64'h7F_FFFF_FFFF;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    mrps_pkg::req_t  request;
    logic            result_valid;
    mrps_pkg::rsp_t  result;
    logic            cfg_write;
    logic [1:0]      cfg_index;
    logic [31:0]     cfg_data;

    // predictor copy of the registers
    logic signed [31:0] mean_q;
    logic        [23:0] variance_q;
    logic        [23:0] rate_q;
    logic        [1:0]  method_q;

    mrps_pkg::rsp_t expected_transitions[$];
    int     failures;
    longint cycles;
    int     send_idle_pct;

    mean_reverting_process_step_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // floor division by a power of two
    function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
        floor_shr = v >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        int_sqrt = r;
    endfunction

    // exp(-x), x in q.24, result q.32
    function automatic logic [63:0] decay(logic [63:0] x24);
        logic [63:0] y30;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] acc;
        logic [127:0] p;
        y30 = (x24 * LOG2E) >> 24;
        k   = y30 >> 30;
        f   = y30 & 64'h3FFF_FFFF;
        if (k >= 32)
            return 0;
        r   = (f * LN2) >> 30;
        acc = ONE;
        for (int n = 12; n >= 1; n--)
        begin
            p   = r * acc;
            acc = ONE - ((p >> 32) / n);
        end
        decay = acc >> k;
    endfunction

    // floor((x*e + m*(1-e)) / 2^32)
    function automatic logic signed [63:0] blend_mean(logic signed [63:0] x,
                                                      logic signed [63:0] m,
                                                      logic [63:0] e);
        logic signed [127:0] a;
        a = x * $signed({64'd0, e}) + m * $signed({64'd0, ONE - e});
        blend_mean = 64'(a >>> 32);
    endfunction

    function automatic logic signed [63:0] diffusion(logic [63:0] sd,
                                                     logic signed [63:0] z);
        diffusion = floor_shr($signed(sd) * z, 28 - FRAC);
    endfunction

    function automatic mrps_pkg::rsp_t predict_transition(mrps_pkg::req_t rq);
        logic signed [63:0] x;
        logic signed [63:0] z;
        logic signed [63:0] z1;
        logic signed [63:0] mu;
        logic signed [63:0] d;
        logic signed [63:0] nxt;
        logic [63:0] tau;
        logic [63:0] x48;
        logic [63:0] x24;
        logic [63:0] x2;
        logic [63:0] e;
        logic [63:0] e2;
        logic [63:0] var_q;
        logic [63:0] sd;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] ad;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] se;
        mrps_pkg::rsp_t rs;
        x   = rq.current_value;
        z   = rq.noise_main;
        z1  = rq.noise_aux;
        mu  = mean_q;
        tau = variance_q;
        x48 = 64'(rate_q) * 64'(rq.time_step);
        x24 = x48 >> 8;
        if (x24 > X_CAP)
            x24 = X_CAP;
        if (method_q == mrps_pkg::METHOD_EULER)
        begin
            hi    = x48 >> 32;
            lo    = x48 & 64'hFFFF_FFFF;
            d     = mu - x;
            ad    = d < 0 ? -d : d;
            mag   = ad * hi + ((ad * lo) >> 32);
            var_q = 2 * (((tau * hi) << 16) + ((tau * lo) >> 16));
            sd    = int_sqrt(var_q);
            nxt   = x + (d < 0 ? -$signed(mag) : $signed(mag)) + diffusion(sd, z);
        end
        else if (method_q == mrps_pkg::METHOD_MIXTURE)
        begin
            e = decay(x24);
            if (e == 0)
                q = GROWTH_CAP;
            else
            begin
                q = ((ONE - e) << 16) / e;
                if (q > GROWTH_CAP)
                    q = GROWTH_CAP;
            end
            var_q = tau * q;
            sd    = int_sqrt(var_q);
            se    = (sd * e) >> 32;
            nxt   = blend_mean(x, mu, e) + diffusion(se, z1) + diffusion(sd, z);
        end
        else
        begin
            // exact transition, also for the unused selector code
            x2 = 2 * x24;
            if (x2 > X_CAP)
                x2 = X_CAP;
            e     = decay(x24);
            e2    = decay(x2);
            var_q = (tau * (ONE - e2)) >> 16;
            sd    = int_sqrt(var_q);
            nxt   = blend_mean(x, mu, e) + diffusion(sd, z);
        end
        rs.saturated = 1'b0;
        if (nxt > 64'sd2147483647)
        begin
            nxt = 64'sd2147483647;
            rs.saturated = 1'b1;
        end
        else if (nxt < -64'sd2147483648)
        begin
            nxt = -64'sd2147483648;
            rs.saturated = 1'b1;
        end
        rs.next_value = nxt[31:0];
        predict_transition = rs;
    endfunction

    // registers are written only with nothing in flight
    task automatic write_register(mrps_pkg::reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            mrps_pkg::REG_LONG_RUN_MEAN:       mean_q     = val;
            mrps_pkg::REG_STATIONARY_VARIANCE: variance_q = val[23:0];
            mrps_pkg::REG_REVERSION_RATE:      rate_q     = val[23:0];
            default:                           method_q   = val[1:0];
        endcase
    endtask

    task automatic drain();
        wait (expected_transitions.size() == 0);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // one request, with a random idle gap in front; typed expectation optional
    task automatic send_request(mrps_pkg::req_t rq, bit typed, mrps_pkg::rsp_t typed_rsp);
        mrps_pkg::rsp_t p;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        start   = 1'b1;
        request = rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = predict_transition(rq);
        if (typed && p !== typed_rsp)
        begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $realtime, typed_rsp, p);
            failures++;
        end
        expected_transitions.push_back(typed ? typed_rsp : p);
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic mrps_pkg::req_t random_request();
        mrps_pkg::req_t rq;
        rq.current_value = $urandom;
        case ($urandom_range(3))
            0:       rq.time_step = $urandom_range(255);
            1:       rq.time_step = $urandom_range(65535);
            2:       rq.time_step = $urandom_range(24'hFFFFFF);
            default: rq.time_step = 24'hFFFFFF - $urandom_range(3);
        endcase
        rq.noise_main = $urandom;
        rq.noise_aux  = $urandom;
        if ($urandom_range(3) == 0)
            rq.current_value = $signed(rq.current_value) >>> $urandom_range(31);
        return rq;
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        mrps_pkg::rsp_t want;
        if (rst_n && result_valid)
        begin
            if (expected_transitions.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h",
                         $realtime, result);
                failures++;
            end
            else
            begin
                want = expected_transitions.pop_front();
                if (result.next_value !== want.next_value)
                begin
                    $display("%0t next_value mismatch: expected %h actual %h",
                             $realtime, want.next_value, result.next_value);
                    failures++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $display("%0t saturated mismatch: expected %b actual %b",
                             $realtime, want.saturated, result.saturated);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // directed table: value, dt, z, z1, typed flag, typed result
    typedef struct {
        mrps_pkg::req_t rq;
        bit             typed;
        mrps_pkg::rsp_t rs;
    } row_t;

    row_t directed[$];

    task automatic add_row(logic [31:0] v, logic [23:0] dt, logic [15:0] z,
                           logic [15:0] z1, bit typed, logic [31:0] nv, bit sat);
        row_t r;
        r.rq.current_value = v;
        r.rq.time_step     = dt;
        r.rq.noise_main    = z;
        r.rq.noise_aux     = z1;
        r.typed            = typed;
        r.rs.next_value    = nv;
        r.rs.saturated     = sat;
        directed.push_back(r);
    endtask

    task automatic random_phase(int n);
        mrps_pkg::rsp_t none;
        none = '0;
        for (int i = 0; i < n; i++)
            send_request(random_request(), 1'b0, none);
    endtask

    task automatic random_registers();
        write_register(mrps_pkg::REG_LONG_RUN_MEAN, $urandom);
        write_register(mrps_pkg::REG_STATIONARY_VARIANCE, $urandom_range(3) == 0 ?
                       $urandom_range(24'hFFFFFF) : $urandom_range(24'h3FFFF));
        write_register(mrps_pkg::REG_REVERSION_RATE, $urandom_range(3) == 0 ?
                       $urandom_range(24'hFFFFFF) : $urandom_range(24'h3FFFF));
        write_register(mrps_pkg::REG_UPDATE_METHOD, $urandom_range(3));
    endtask

    initial
    begin
        failures      = 0;
        cycles        = 0;
        send_idle_pct = 29;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_write = 1'b0;
        cfg_index = mrps_pkg::REG_LONG_RUN_MEAN;
        cfg_data  = '0;
        mean_q     = '0;
        variance_q = 24'd65536;
        rate_q     = 24'd65536;
        method_q   = mrps_pkg::METHOD_EXACT;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // after reset: dt 0 keeps value, zero variance, so noise has no effect
        add_row(32'h0001_0000, 24'd0, 16'h7FFF, 16'h8000, 1'b1, 32'h0001_0000, 1'b0);
        add_row(32'h7FFF_FFFF, 24'd0, 16'h0000, 16'h0000, 1'b1, 32'h7FFF_FFFF, 1'b0);
        add_row(32'h8000_0000, 24'd0, 16'h8000, 16'h7FFF, 1'b1, 32'h8000_0000, 1'b0);
        // huge alpha*dt collapses the blend onto the mean; last row a unit step
        add_row(32'h7FFF_FFFF, 24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, '0, 1'b0);
        add_row(32'h8000_0000, 24'hFFFFFF, 16'h7FFF, 16'h8000, 1'b0, '0, 1'b0);
        add_row(32'h0000_0000, 24'h010000, 16'h1000, 16'h0000, 1'b0, '0, 1'b0);
        for (int m = 0; m < 4; m++)
        begin
            foreach (directed[i])
                send_request(directed[i].rq, directed[i].typed, directed[i].rs);
            drain();
            // next method, extreme registers for overflow
            write_register(mrps_pkg::REG_UPDATE_METHOD, (m + 1) % 4);
            write_register(mrps_pkg::REG_STATIONARY_VARIANCE,
                           m[0] ? 32'hFFFFFF : 32'd65536);
            write_register(mrps_pkg::REG_REVERSION_RATE, m[1] ? 32'hFFFFFF : 32'd0);
            write_register(mrps_pkg::REG_LONG_RUN_MEAN,
                           m[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
            directed.delete();
            add_row(32'h7FFF_FFFF, 24'hFFFFFF, 16'h7FFF, 16'h7FFF, 1'b0, '0, 1'b0);
            add_row(32'h8000_0000, 24'hFFFFFF, 16'h8000, 16'h8000, 1'b0, '0, 1'b0);
            add_row(32'h0000_0000, 24'h000001, 16'h7FFF, 16'h8000, 1'b0, '0, 1'b0);
            add_row(32'h7FFF_FFFF, 24'h010000, 16'h7FFF, 16'h7FFF, 1'b0, '0, 1'b0);
        end

        // random part: three idling regimes, registers changed between blocks
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 51 : 0;
            for (int b = 0; b < 6; b++)
            begin
                drain();
                random_registers();
                random_phase(55);
            end
        end

        wait (expected_transitions.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
src/mrps_pkg.sv
src/mrps_exp.sv
src/mrps_div.sv
src/mrps_sqrt.sv
src/mean_reverting_process_step_unit.sv
bench/tb.sv
